FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SPI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define SPI_ASSERT_NEVER(label, cond, msg) \
    `SPI_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared constants and types of the segment pair intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // Width of one result coordinate and of the divider quotient.
    localparam int OUT_W       = 24;
    localparam int OUT_TDATA_W = 2 * OUT_W;
    localparam int OUT_TUSER_W = 2;

    // Bit positions inside the result tuser.
    localparam int TUSER_HIT = 0;
    localparam int TUSER_PAR = 1;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic hit;
        logic par;
        logic neg_x;
        logic neg_y;
    } spi_meta_t;

endpackage

`default_nettype wire

FILE: rtl/segment_pair_intersection.sv
// Pipeline: five arithmetic stages, OUT_W + 1 divider stages and one output
// register between an accepted input item and its result item.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset clears every valid bit and the delayed flags; data registers are not reset.
// ----------------------------------------------------------------------------
// segment_pair_intersection
// Exact integer segment crossing test with a fixed point crossing point.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_pair_intersection #(
    parameter int COORD_WIDTH = spi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = spi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  wire logic [8*COORD_WIDTH-1:0]         s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // cross_x, cross_y
    output logic      [spi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // intersects, parallel
    output logic      [spi_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import spi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DFW  = W + 1;
    localparam int PW   = 2 * W + 2;
    localparam int OW   = 2 * W + 3;
    localparam int DW   = 2 * W + 2;
    localparam int PNW  = 3 * W + 4;
    localparam int NW   = 3 * W + 5;
    localparam int SW   = (NW + FRAC_BITS > OUT_W) ? NW + FRAC_BITS : OUT_W + 1;
    localparam int DLAT = OUT_W + 1;

    function automatic logic in_span(input logic signed [W-1:0] x,
                                     input logic signed [W-1:0] p,
                                     input logic signed [W-1:0] q);
        in_span = ((x >= p) && (x <= q)) || ((x >= q) && (x <= p));
    endfunction

    function automatic logic [OUT_W-1:0] fix_out(input logic [OUT_W-1:0] q,
                                                 input logic ov,
                                                 input logic neg);
        logic [OUT_W-1:0] r;
        if (!neg)
            r = (ov || q[OUT_W-1]) ? OUT_MAX : q;
        else
            r = (ov || (q > OUT_MIN)) ? OUT_MIN : (~q + 1'b1);
        fix_out = r;
    endfunction

    logic en;
    logic m_valid_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

    assign ax1 = s_axis_tdata[0*W +: W];
    assign ay1 = s_axis_tdata[1*W +: W];
    assign ax2 = s_axis_tdata[2*W +: W];
    assign ay2 = s_axis_tdata[3*W +: W];
    assign bx1 = s_axis_tdata[4*W +: W];
    assign by1 = s_axis_tdata[5*W +: W];
    assign bx2 = s_axis_tdata[6*W +: W];
    assign by2 = s_axis_tdata[7*W +: W];

    // Stage 1: edge vectors and bounding box tests.
    logic v1_reg;
    logic signed [DFW-1:0] dax1_reg, day1_reg, dbx1_reg, dby1_reg;
    logic signed [DFW-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [DFW-1:0] f1x_reg, f1y_reg, f2x_reg, f2y_reg;
    logic signed [W-1:0]   ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic [3:0]            box1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax1_reg <= DFW'(ax2) - DFW'(ax1);
            day1_reg <= DFW'(ay2) - DFW'(ay1);
            dbx1_reg <= DFW'(bx2) - DFW'(bx1);
            dby1_reg <= DFW'(by2) - DFW'(by1);
            e1x_reg  <= DFW'(bx1) - DFW'(ax2);
            e1y_reg  <= DFW'(by1) - DFW'(ay2);
            e2x_reg  <= DFW'(bx2) - DFW'(ax2);
            e2y_reg  <= DFW'(by2) - DFW'(ay2);
            f1x_reg  <= DFW'(ax1) - DFW'(bx2);
            f1y_reg  <= DFW'(ay1) - DFW'(by2);
            f2x_reg  <= DFW'(ax2) - DFW'(bx2);
            f2y_reg  <= DFW'(ay2) - DFW'(by2);
            ax1_reg  <= ax1;
            ay1_reg  <= ay1;
            bx1_reg  <= bx1;
            by1_reg  <= by1;
            box1_reg <= {in_span(ax2, bx1, bx2) && in_span(ay2, by1, by2),
                         in_span(ax1, bx1, bx2) && in_span(ay1, by1, by2),
                         in_span(bx2, ax1, ax2) && in_span(by2, ay1, ay2),
                         in_span(bx1, ax1, ax2) && in_span(by1, ay1, ay2)};
        end
    end

    // Stage 2: all cross products.
    logic v2_reg;
    logic signed [PW-1:0]  o1a_reg, o1b_reg, o2a_reg, o2b_reg;
    logic signed [PW-1:0]  o3a_reg, o3b_reg, o4a_reg, o4b_reg;
    logic signed [PW-1:0]  c1a_reg, c1b_reg, c2a_reg, c2b_reg, dta_reg, dtb_reg;
    logic signed [DFW-1:0] dax2_reg, day2_reg, dbx2_reg, dby2_reg;
    logic [3:0]            box2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o1a_reg  <= PW'(day1_reg * e1x_reg);
            o1b_reg  <= PW'(dax1_reg * e1y_reg);
            o2a_reg  <= PW'(day1_reg * e2x_reg);
            o2b_reg  <= PW'(dax1_reg * e2y_reg);
            o3a_reg  <= PW'(dby1_reg * f1x_reg);
            o3b_reg  <= PW'(dbx1_reg * f1y_reg);
            o4a_reg  <= PW'(dby1_reg * f2x_reg);
            o4b_reg  <= PW'(dbx1_reg * f2y_reg);
            c1a_reg  <= PW'(day1_reg * DFW'(ax1_reg));
            c1b_reg  <= PW'(dax1_reg * DFW'(ay1_reg));
            c2a_reg  <= PW'(dby1_reg * DFW'(bx1_reg));
            c2b_reg  <= PW'(dbx1_reg * DFW'(by1_reg));
            dta_reg  <= PW'(dby1_reg * dax1_reg);
            dtb_reg  <= PW'(day1_reg * dbx1_reg);
            dax2_reg <= dax1_reg;
            day2_reg <= day1_reg;
            dbx2_reg <= dbx1_reg;
            dby2_reg <= dby1_reg;
            box2_reg <= box1_reg;
        end
    end

    // Stage 3: orientation signs, line constants and determinant.
    logic signed [OW-1:0] o1, o2, o3, o4;

    assign o1 = OW'(o1a_reg) - OW'(o1b_reg);
    assign o2 = OW'(o2a_reg) - OW'(o2b_reg);
    assign o3 = OW'(o3a_reg) - OW'(o3b_reg);
    assign o4 = OW'(o4a_reg) - OW'(o4b_reg);

    logic v3_reg;
    logic [3:0]            oz_reg, on_reg;
    logic signed [OW-1:0]  c1_reg, c2_reg, det3_reg;
    logic signed [DFW-1:0] dax3_reg, day3_reg, dbx3_reg, dby3_reg;
    logic [3:0]            box3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oz_reg   <= {o4 == '0, o3 == '0, o2 == '0, o1 == '0};
            on_reg   <= {o4[OW-1], o3[OW-1], o2[OW-1], o1[OW-1]};
            c1_reg   <= OW'(c1a_reg) - OW'(c1b_reg);
            c2_reg   <= OW'(c2a_reg) - OW'(c2b_reg);
            det3_reg <= OW'(dta_reg) - OW'(dtb_reg);
            dax3_reg <= dax2_reg;
            day3_reg <= day2_reg;
            dbx3_reg <= dbx2_reg;
            dby3_reg <= dby2_reg;
            box3_reg <= box2_reg;
        end
    end

    // Stage 4: intersection decision and numerator products.
    logic hit;

    // Signs match when both the zero flags and the negative flags match.
    assign hit = (((oz_reg[0] != oz_reg[1]) || (on_reg[0] != on_reg[1]))
                  && ((oz_reg[2] != oz_reg[3]) || (on_reg[2] != on_reg[3])))
               || |(oz_reg & box3_reg);

    logic v4_reg;
    logic                  hit4_reg;
    logic signed [PNW-1:0] pdaxc2_reg, pdbxc1_reg, pdayc2_reg, pdbyc1_reg;
    logic signed [OW-1:0]  det4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit4_reg   <= hit;
            pdaxc2_reg <= PNW'(dax3_reg * c2_reg);
            pdbxc1_reg <= PNW'(dbx3_reg * c1_reg);
            pdayc2_reg <= PNW'(day3_reg * c2_reg);
            pdbyc1_reg <= PNW'(dby3_reg * c1_reg);
            det4_reg   <= det3_reg;
        end
    end

    // Stage 5: signed numerators to magnitudes, scaled by the fraction bits.
    logic signed [NW-1:0] numx, numy;
    logic signed [OW-1:0] det_abs;

    assign numx    = NW'(pdaxc2_reg) - NW'(pdbxc1_reg);
    assign numy    = NW'(pdayc2_reg) - NW'(pdbyc1_reg);
    assign det_abs = det4_reg[OW-1] ? -det4_reg : det4_reg;

    logic v5_reg;
    spi_meta_t        meta5_reg;
    logic [SW-1:0]    numx5_reg, numy5_reg;
    logic [DW-1:0]    den5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta5_reg.valid <= v4_reg;
            meta5_reg.hit   <= hit4_reg;
            meta5_reg.par   <= hit4_reg && (det4_reg == '0);
            meta5_reg.neg_x <= numx[NW-1] ^ det4_reg[OW-1];
            meta5_reg.neg_y <= numy[NW-1] ^ det4_reg[OW-1];
            numx5_reg <= SW'(numx[NW-1] ? NW'(-numx) : NW'(numx)) << FRAC_BITS;
            numy5_reg <= SW'(numy[NW-1] ? NW'(-numy) : NW'(numy)) << FRAC_BITS;
            den5_reg  <= DW'(det_abs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    spi_meta_t meta5;

    always_comb
    begin
        meta5       = meta5_reg;
        meta5.valid = v5_reg;
    end

    // Dividers, with the item flags delayed alongside.
    logic [OUT_W-1:0] quot_x, quot_y;
    logic             ovf_x, ovf_y;

    spi_divider #(.NUM_W(SW), .DEN_W(DW)) u_div_x (
        .clk  (clk),
        .en   (en),
        .num  (numx5_reg),
        .den  (den5_reg),
        .quot (quot_x),
        .ovf  (ovf_x)
    );

    spi_divider #(.NUM_W(SW), .DEN_W(DW)) u_div_y (
        .clk  (clk),
        .en   (en),
        .num  (numy5_reg),
        .den  (den5_reg),
        .quot (quot_y),
        .ovf  (ovf_y)
    );

    spi_meta_t meta_reg [0:DLAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DLAT; i++)
            begin
                meta_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            meta_reg[0] <= meta5;
            for (int i = 1; i < DLAT; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    // Output register.
    spi_meta_t        mo;
    logic             show_pt;
    logic [OUT_W-1:0] cx_reg, cy_reg;
    logic             hit_reg, par_reg;

    assign mo      = meta_reg[DLAT-1];
    assign show_pt = mo.hit && !mo.par;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= mo.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= mo.hit;
            par_reg <= mo.par;
            cx_reg  <= show_pt ? fix_out(quot_x, ovf_x, mo.neg_x) : '0;
            cy_reg  <= show_pt ? fix_out(quot_y, ovf_y, mo.neg_y) : '0;
        end
    end

    assign m_axis_tvalid            = m_valid_reg;
    assign m_axis_tdata             = {cy_reg, cx_reg};
    assign m_axis_tuser[TUSER_HIT]  = hit_reg;
    assign m_axis_tuser[TUSER_PAR]  = par_reg;

endmodule

`default_nettype wire

FILE: rtl/spi_divider.sv
// ----------------------------------------------------------------------------
// spi_divider
// Pipelined restoring divider: one quotient bit per stage, with an up-front
// overflow check when the quotient does not fit in OUT_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_divider #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 34
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [NUM_W-1:0]         num,
    input  wire logic [DEN_W-1:0]         den,
    output logic      [spi_pkg::OUT_W-1:0] quot,
    output logic                          ovf
);
    import spi_pkg::*;

    localparam int QW = OUT_W;
    localparam int TW = NUM_W - QW;
    localparam int CW = (TW > DEN_W) ? TW : DEN_W;

    logic [DEN_W-1:0] rem_reg [0:QW-1];
    logic [QW-1:0]    low_reg [0:QW-1];
    logic [DEN_W-1:0] den_reg [0:QW-1];
    logic [QW-1:0]    q_reg   [0:QW];
    logic             ovf_reg [0:QW];

    logic [TW-1:0] num_top;

    assign num_top = num[NUM_W-1:QW];

    // The high part must already be below the divisor, or the quotient is too wide.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(num_top);
            low_reg[0] <= num[QW-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (CW'(num_top) >= CW'(den));
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           ge;

        assign trial = {rem_reg[k-1], low_reg[k-1][QW-1]};
        assign ge    = (trial >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < QW)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? DEN_W'(trial - {1'b0, den_reg[k-1]}) : DEN_W'(trial);
                    low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quot = q_reg[QW];
    assign ovf  = ovf_reg[QW];

endmodule

`default_nettype wire

FILE: rtl/spi_checker.sv
// ----------------------------------------------------------------------------
// spi_checker
// Port level checks of the segment pair intersection block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spi_checker #(
    parameter int COORD_WIDTH = spi_pkg::COORD_WIDTH_DEF
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [8*COORD_WIDTH-1:0]         s_axis_tdata,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [spi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic [spi_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import spi_pkg::*;

    logic in_seen;

    // An input item only counts when it is offered with a known payload.
    assign in_seen = s_axis_tvalid && s_axis_tready && (^s_axis_tdata !== 1'bx);

    `SPI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result item changed")
    `SPI_ASSERT(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while the output is stalled")
    `SPI_ASSERT_NEVER(a_par_needs_hit, m_axis_tvalid && m_axis_tuser[TUSER_PAR] && !m_axis_tuser[TUSER_HIT], "parallel without intersection")
    `SPI_ASSERT(a_no_point, m_axis_tvalid && (!m_axis_tuser[TUSER_HIT] || m_axis_tuser[TUSER_PAR]) |-> m_axis_tdata == '0, "point given without a single crossing")
    `SPI_ASSERT_NEVER(a_ready_unknown, in_seen && $isunknown(s_axis_tready), "input ready unknown")

endmodule

bind segment_pair_intersection spi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_spi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Segment pair intersection testbench
// Streams segment pairs into the block and checks each result item against a
// predictor of the crossing test and the fixed point crossing point. Both
// sides idle at random. There is one long output stall and one full drain
// pause.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int CW        = spi_pkg::COORD_WIDTH_DEF;
    localparam int FB        = spi_pkg::FRAC_BITS_DEF;
    localparam int OW        = spi_pkg::OUT_W;
    localparam int N_RANDOM  = 530;
    localparam int LATENCY   = 31;
    localparam int LIMIT     = 200000;
    localparam int STALL_AT  = 500;
    localparam int STALL_LEN = 200;
    localparam int CALM_LO   = 100;
    localparam int CALM_HI   = 300;
    localparam int DRAIN_AT  = 350;

    typedef struct packed {
        logic          hit;
        logic          par;
        logic [OW-1:0] cx;
        logic [OW-1:0] cy;
    } crossing_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [8*CW-1:0]       s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [spi_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [spi_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

    logic [8*CW-1:0] pair_q[$];
    crossing_t       crossing_q[$];
    int              cycle_cnt;
    int              sent_cnt;
    int              errors;
    bit              stim_done;

    segment_pair_intersection DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int orient_sign(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
        longint v;
        v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic bit in_box(longint x, longint y, longint x1, longint y1,
                                  longint x2, longint y2);
        return x >= ((x1 < x2) ? x1 : x2) && x <= ((x1 < x2) ? x2 : x1)
            && y >= ((y1 < y2) ? y1 : y2) && y <= ((y1 < y2) ? y2 : y1);
    endfunction

    // Truncating signed division, then clamp to the result range.
    function automatic logic [OW-1:0] fixed_quotient(logic signed [127:0] num,
                                                     logic signed [127:0] den);
        logic signed [127:0] q;
        q = (num <<< FB) / den;
        if (q > 128'sd8388607)
            q = 128'sd8388607;
        if (q < -128'sd8388608)
            q = -128'sd8388608;
        return q[OW-1:0];
    endfunction

    function automatic crossing_t predict_crossing(logic [8*CW-1:0] d);
        longint              c[8];
        int                  o1, o2, o3, o4;
        logic signed [127:0] a1, b1, c1, a2, b2, c2, det;
        crossing_t           r;
        for (int i = 0; i < 8; i++)
            c[i] = longint'($signed(d[i*CW +: CW]));
        o1 = orient_sign(c[0], c[1], c[2], c[3], c[4], c[5]);
        o2 = orient_sign(c[0], c[1], c[2], c[3], c[6], c[7]);
        o3 = orient_sign(c[4], c[5], c[6], c[7], c[0], c[1]);
        o4 = orient_sign(c[4], c[5], c[6], c[7], c[2], c[3]);
        r = '0;
        r.hit = (o1 != o2 && o3 != o4)
             || (o1 == 0 && in_box(c[4], c[5], c[0], c[1], c[2], c[3]))
             || (o2 == 0 && in_box(c[6], c[7], c[0], c[1], c[2], c[3]))
             || (o3 == 0 && in_box(c[0], c[1], c[4], c[5], c[6], c[7]))
             || (o4 == 0 && in_box(c[2], c[3], c[4], c[5], c[6], c[7]));
        if (r.hit)
        begin
            a1  = c[3] - c[1];
            b1  = c[0] - c[2];
            c1  = a1 * c[0] + b1 * c[1];
            a2  = c[7] - c[5];
            b2  = c[4] - c[6];
            c2  = a2 * c[4] + b2 * c[5];
            det = a1 * b2 - a2 * b1;
            if (det == 0)
                r.par = 1'b1;
            else
            begin
                r.cx = fixed_quotient(b2 * c1 - b1 * c2, det);
                r.cy = fixed_quotient(a1 * c2 - a2 * c1, det);
            end
        end
        return r;
    endfunction

    function automatic logic [8*CW-1:0] pack_pair(int ax1, int ay1, int ax2, int ay2,
                                                  int bx1, int by1, int bx2, int by2);
        logic [CW-1:0] ax1_v, ay1_v, ax2_v, ay2_v, bx1_v, by1_v, bx2_v, by2_v;
        ax1_v = ax1[CW-1:0];
        ay1_v = ay1[CW-1:0];
        ax2_v = ax2[CW-1:0];
        ay2_v = ay2[CW-1:0];
        bx1_v = bx1[CW-1:0];
        by1_v = by1[CW-1:0];
        bx2_v = bx2[CW-1:0];
        by2_v = by2[CW-1:0];
        return {by2_v, bx2_v, by1_v, bx1_v, ay2_v, ax2_v, ay1_v, ax1_v};
    endfunction

    function automatic int rnd_coord(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic bit calm();
        return cycle_cnt >= CALM_LO && cycle_cnt < CALM_HI;
    endfunction

    initial
    begin
        int cx, cy, dx, dy, ex, ey, span, kind, n_items;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        errors        = 0;
        stim_done     = 1'b0;

        // Directed cases: proper crossing, disjoint, touching ends, collinear
        // overlap and gap, degenerate points, parallel lines, extremes.
        pair_q.push_back(pack_pair(0, 0, 10, 10, 0, 10, 10, 0));
        pair_q.push_back(pack_pair(-5, 3, 7, -2, 1, -9, 2, 8));
        pair_q.push_back(pack_pair(0, 0, 1, 1, 5, 5, 9, 2));
        pair_q.push_back(pack_pair(0, 0, 4, 0, 4, 0, 4, 7));
        pair_q.push_back(pack_pair(0, 0, 4, 0, 2, 0, 2, 5));
        pair_q.push_back(pack_pair(0, 0, 8, 8, 4, 4, 12, 12));
        pair_q.push_back(pack_pair(0, 0, 2, 2, 5, 5, 9, 9));
        pair_q.push_back(pack_pair(3, 3, 3, 3, 0, 0, 6, 6));
        pair_q.push_back(pack_pair(3, 3, 3, 3, 3, 3, 3, 3));
        pair_q.push_back(pack_pair(3, 3, 3, 3, 4, 4, 4, 4));
        pair_q.push_back(pack_pair(0, 0, 10, 0, 0, 1, 10, 1));
        pair_q.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pair_q.push_back(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        pair_q.push_back(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        pair_q.push_back(pack_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        pair_q.push_back(pack_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        pair_q.push_back(pack_pair(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767));
        pair_q.push_back(pack_pair(1, 2, 3, 5, 0, 7, 4, 1));
        pair_q.push_back(pack_pair(32767, 32767, -32768, -32768, 0, 0, 32767, 32767));
        pair_q.push_back(pack_pair(0, 0, 3, 7, 1, 0, 2, 9));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 9);
            span = ($urandom_range(0, 3) == 0) ? 32767 : (1 << $urandom_range(2, 12));
            if (kind < 2)
                pair_q.push_back({$urandom, $urandom, $urandom, $urandom});
            else if (kind < 4)
                pair_q.push_back(pack_pair(rnd_coord(4), rnd_coord(4), rnd_coord(4),
                                           rnd_coord(4), rnd_coord(4), rnd_coord(4),
                                           rnd_coord(4), rnd_coord(4)));
            else if (kind < 5)
            begin
                // Collinear pieces of one line, often overlapping.
                dx = rnd_coord(5);
                dy = rnd_coord(5);
                cx = rnd_coord(1000);
                cy = rnd_coord(1000);
                pair_q.push_back(pack_pair(cx, cy, cx + 4 * dx, cy + 4 * dy,
                                           cx + rnd_coord(6) * dx, cy + rnd_coord(6) * dy,
                                           cx + rnd_coord(6) * dx, cy + rnd_coord(6) * dy));
            end
            else
            begin
                // Two segments through a common center, crossing by construction.
                span = span / 2;
                cx = rnd_coord(span);
                cy = rnd_coord(span);
                dx = rnd_coord(span);
                dy = rnd_coord(span);
                ex = rnd_coord(span);
                ey = rnd_coord(span);
                pair_q.push_back(pack_pair(cx - dx, cy - dy, cx + dx, cy + dy,
                                           cx + ex, cy + ey, cx - ex / 2, cy - ey / 2));
            end
        end
        n_items = pair_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        stim_done = 1'b1;

        wait (sent_cnt == n_items && crossing_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && crossing_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Sender: holds an item until it is taken, idles at random, and stops once
    // to let every pending result drain.
    always @(posedge clk or negedge rst_n)
    begin
        logic            offer;
        logic [8*CW-1:0] next_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            sent_cnt      <= 0;
        end
        else
        begin
            next_data = s_axis_tdata;
            offer     = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                crossing_q.push_back(predict_crossing(s_axis_tdata));
                sent_cnt <= sent_cnt + 1;
                offer = 1'b0;
            end
            if (!offer && stim_done && pair_q.size() != 0
                && !(sent_cnt == DRAIN_AT && crossing_q.size() != 0)
                && (calm() || $urandom_range(0, 99) >= 35))
            begin
                next_data = pair_q.pop_front();
                offer     = 1'b1;
            end
            s_axis_tvalid <= offer;
            s_axis_tdata  <= next_data;
        end
    end

    // Receiver: random ready with one long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (cycle_cnt >= STALL_AT && cycle_cnt < STALL_AT + STALL_LEN)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm() || $urandom_range(0, 99) >= 35;
    end

    always @(posedge clk)
    begin
        crossing_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.hit = m_axis_tuser[spi_pkg::TUSER_HIT];
            got.par = m_axis_tuser[spi_pkg::TUSER_PAR];
            got.cx  = m_axis_tdata[OW-1:0];
            got.cy  = m_axis_tdata[2*OW-1:OW];
            if (crossing_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item %h", $time, got);
            end
            else
            begin
                want = crossing_q.pop_front();
                if (got.hit != want.hit)
                begin
                    errors++;
                    $display("%0t: intersects expected %b got %b", $time, want.hit, got.hit);
                end
                if (got.par != want.par)
                begin
                    errors++;
                    $display("%0t: parallel expected %b got %b", $time, want.par, got.par);
                end
                if (got.cx != want.cx)
                begin
                    errors++;
                    $display("%0t: cross_x expected %h got %h", $time, want.cx, got.cx);
                end
                if (got.cy != want.cy)
                begin
                    errors++;
                    $display("%0t: cross_y expected %h got %h", $time, want.cy, got.cy);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            cycle_cnt <= 0;
        else
            cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire
